// ===== rtl/mme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

  localparam int MaxNDefault        = 16;
  localparam int ElementBitsDefault = 16;
  localparam int ResultBits         = 36;
  localparam int SizeBits           = 5;
  localparam int KindBits           = 2;
  localparam int IdxBits            = 4;

  typedef enum logic [KindBits-1:0] {
    KindWriteA = 2'd0,
    KindWriteB = 2'd1,
    KindReadC  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDrain,
    StResp
  } state_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mme_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_store #(
  parameter int Depth = 256,
  parameter int Width = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/mme_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_mac #(
  parameter int ElementBits = mme_pkg::ElementBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mme_pkg::mac_ctl_t               ctl_i,
  input  wire logic [ElementBits-1:0]          a_i,
  input  wire logic [ElementBits-1:0]          b_i,
  output logic      [mme_pkg::ResultBits-1:0]  acc_o,
  output logic                                 busy_o
);

  import mme_pkg::*;

  localparam int ProdBits = 2 * ElementBits;

  logic signed [ElementBits-1:0] a_s, b_s;
  logic signed [ProdBits-1:0]    prod_d, prod_q;
  logic                          prod_vld_q;
  logic [ResultBits-1:0]         prod_ext;
  logic [ResultBits-1:0]         acc_d, acc_q;

  assign a_s    = $signed(a_i);
  assign b_s    = $signed(b_i);
  assign prod_d = a_s * b_s;

  generate
    if (ProdBits >= ResultBits) begin : g_trunc
      assign prod_ext = prod_q[ResultBits-1:0];
    end else begin : g_sext
      assign prod_ext = {{(ResultBits-ProdBits){prod_q[ProdBits-1]}}, prod_q};
    end
  endgenerate

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = ctl_i.vld | prod_vld_q;

endmodule

`default_nettype wire

// ===== rtl/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Write of an A or B element: busy stays low, so the next beat is taken the cycle after.
// C read in range: busy through n store reads into the shared MAC, then while the
// read/multiply/accumulate pipe empties, then for the strobe cycle.
// C read out of range: busy only for the strobe cycle, result 0 with out_of_range_o set.
// The result sits on the ports for one cycle under done_o; the receiver cannot stall.
// Async active-low reset clears control and sets size_q to MAX_N; stores are not cleared.
module matrix_multiply_engine #(
  parameter int MAX_N        = mme_pkg::MaxNDefault,
  parameter int ELEMENT_BITS = mme_pkg::ElementBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mme_pkg::SizeBits-1:0]    cfg_data_i,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [mme_pkg::KindBits-1:0]    kind_i,
  input  wire logic [mme_pkg::IdxBits-1:0]     row_i,
  input  wire logic [mme_pkg::IdxBits-1:0]     col_i,
  input  wire logic signed [ELEMENT_BITS-1:0]  element_i,
  output logic                                 done_o,
  output logic signed [mme_pkg::ResultBits-1:0] product_value_o,
  output logic                                 out_of_range_o
);

  import mme_pkg::*;

  localparam int Depth = MAX_N * MAX_N;
  localparam int AW    = $clog2(Depth);
  localparam int KW    = $clog2(MAX_N);
  localparam int NW    = $clog2(MAX_N + 1);
  localparam int SQW   = (NW > SizeBits) ? NW : SizeBits;

  state_e state_q, state_d;

  logic [SQW-1:0]     size_q;
  logic [NW-1:0]      n_eff;
  logic [IdxBits-1:0] row_q, col_q;
  logic [KW-1:0]      k_q, k_d;
  logic               oor_q, oor_d;
  logic               rd_vld_q;
  logic               accept, is_write, wr_ok, req_oor, issue, last_k;
  logic               we_a, we_b;
  logic [AW-1:0]      wr_addr, a_addr, b_addr;
  logic [ELEMENT_BITS-1:0] a_data, b_data;
  logic [ResultBits-1:0]   acc;
  logic               mac_busy;
  mac_ctl_t           mac_ctl;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SQW'(MAX_N);
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= SQW'(cfg_data_i);
    end
  end

  always_comb begin
    if (size_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(size_q) > MAX_N) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(size_q);
    end
  end

  // command decode
  assign accept   = start && !busy;
  assign is_write = (kind_i == KindWriteA) || (kind_i == KindWriteB);
  assign wr_ok    = (int'(row_i) < MAX_N) && (int'(col_i) < MAX_N);
  assign we_a     = accept && (kind_i == KindWriteA) && wr_ok;
  assign we_b     = accept && (kind_i == KindWriteB) && wr_ok;
  assign req_oor  = (int'(row_i) >= int'(n_eff)) || (int'(col_i) >= int'(n_eff));
  assign wr_addr  = AW'(int'(row_i) * MAX_N + int'(col_i));

  assign issue  = (state_q == StRun);
  assign last_k = (int'(k_q) == int'(n_eff) - 1);
  assign a_addr = AW'(int'(row_q) * MAX_N + int'(k_q));
  assign b_addr = AW'(int'(k_q) * MAX_N + int'(col_q));

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    oor_d       = oor_q;
    mac_ctl.clr = 1'b0;
    mac_ctl.vld = rd_vld_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (kind_i == KindReadC)) begin
          mac_ctl.clr = 1'b1;
          k_d         = '0;
          oor_d       = req_oor;
          state_d     = req_oor ? StResp : StRun;
        end
      end
      StRun: begin
        k_d = k_q + KW'(1);
        if (last_k) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!mac_busy) begin
          state_d = StResp;
        end
      end
      StResp: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_vld_q <= 1'b0;
      k_q      <= '0;
      oor_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      k_q      <= k_d;
      oor_q    <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_write) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  mme_store #(
    .Depth (Depth),
    .Width (ELEMENT_BITS)
  ) u_store_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .wr_addr_i (wr_addr),
    .wr_data_i (element_i),
    .rd_addr_i (a_addr),
    .rd_data_o (a_data)
  );

  mme_store #(
    .Depth (Depth),
    .Width (ELEMENT_BITS)
  ) u_store_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .wr_addr_i (wr_addr),
    .wr_data_i (element_i),
    .rd_addr_i (b_addr),
    .rd_data_o (b_data)
  );

  mme_mac #(
    .ElementBits (ELEMENT_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_data),
    .b_i    (b_data),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  assign busy            = (state_q != StIdle);
  assign done_o          = (state_q == StResp);
  assign product_value_o = $signed(acc);
  assign out_of_range_o  = oor_q;

endmodule

`default_nettype wire

// ===== rtl/mme_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mme_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [mme_pkg::KindBits-1:0]    kind_i,
  input  wire logic                            done_o,
  input  wire logic [mme_pkg::ResultBits-1:0]  product_value_o,
  input  wire logic                            out_of_range_o
);

  import mme_pkg::*;

  a_read_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == KindReadC) |=> busy)
    else $error("C read beat did not raise busy");

  a_other_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i != KindReadC) |=> !busy)
    else $error("write or ignored beat raised busy");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a request");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> (product_value_o == '0))
    else $error("out-of-range result not zero");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .kind_i          (kind_i),
  .done_o          (done_o),
  .product_value_o (product_value_o),
  .out_of_range_o  (out_of_range_o)
);

`default_nettype wire

// ===== sim/tb_matrix_multiply_engine.sv =====
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int MaxN   = MaxNDefault;
  localparam int Depth  = MaxN * MaxN;
  localparam int Phases = 8;
  localparam logic [KindBits-1:0] KindSpare = 2'd3;

  typedef struct packed {
    logic signed [ResultBits-1:0] value;
    logic                         oor;
  } c_entry_t;

  typedef struct packed {
    logic [KindBits-1:0]          kind;
    logic [IdxBits-1:0]           row;
    logic [IdxBits-1:0]           col;
    logic signed [15:0]           elem;
    logic                         typed;
    logic signed [ResultBits-1:0] value;
    logic                         oor;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [SizeBits-1:0]          cfg_data_i;
  logic                         start;
  logic                         busy;
  logic [KindBits-1:0]          kind_i;
  logic [IdxBits-1:0]           row_i;
  logic [IdxBits-1:0]           col_i;
  logic signed [15:0]           element_i;
  logic                         done_o;
  logic signed [ResultBits-1:0] product_value_o;
  logic                         out_of_range_o;

  logic signed [15:0] a_elems  [Depth];
  logic signed [15:0] b_elems  [Depth];
  bit                 a_loaded [Depth];
  bit                 b_loaded [Depth];
  logic [SizeBits-1:0] size_reg;
  c_entry_t           pending_entries [$];
  int                 mismatch_count;
  int                 idle_pct;

  // size 1 throughout; reads at row or column 1 and above go beyond n
  dir_row_t directed_rows [19] = '{
    '{KindWriteA, 4'd0,  4'd0,  16'sh8000, 1'b0, 36'sd0,          1'b0},
    '{KindWriteB, 4'd0,  4'd0,  16'sh8000, 1'b0, 36'sd0,          1'b0},
    '{KindReadC,  4'd0,  4'd0,  16'sh0000, 1'b1, 36'sd1073741824, 1'b0},
    '{KindWriteA, 4'd0,  4'd0,  16'sh7fff, 1'b0, 36'sd0,          1'b0},
    '{KindReadC,  4'd0,  4'd0,  16'sh0000, 1'b1, -36'sd1073709056, 1'b0},
    '{KindWriteB, 4'd0,  4'd0,  16'sh7fff, 1'b0, 36'sd0,          1'b0},
    '{KindReadC,  4'd0,  4'd0,  16'shffff, 1'b1, 36'sd1073676289, 1'b0},
    '{KindReadC,  4'd0,  4'd1,  16'sh0000, 1'b1, 36'sd0,          1'b1},
    '{KindReadC,  4'd1,  4'd0,  16'sh0000, 1'b1, 36'sd0,          1'b1},
    '{KindReadC,  4'd15, 4'd15, 16'shffff, 1'b1, 36'sd0,          1'b1},
    '{KindWriteA, 4'd15, 4'd15, 16'shffff, 1'b0, 36'sd0,          1'b0},
    '{KindWriteB, 4'd15, 4'd15, 16'sh5555, 1'b0, 36'sd0,          1'b0},
    '{KindSpare,  4'd15, 4'd15, 16'shffff, 1'b0, 36'sd0,          1'b0},
    '{KindWriteA, 4'd0,  4'd0,  16'sh0000, 1'b0, 36'sd0,          1'b0},
    '{KindReadC,  4'd0,  4'd0,  16'sh0000, 1'b1, 36'sd0,          1'b0},
    '{KindWriteA, 4'd0,  4'd0,  16'shffff, 1'b0, 36'sd0,          1'b0},
    '{KindReadC,  4'd0,  4'd0,  16'sh0000, 1'b1, -36'sd32767,     1'b0},
    '{KindWriteB, 4'd0,  4'd0,  16'shaaaa, 1'b0, 36'sd0,          1'b0},
    '{KindReadC,  4'd0,  4'd0,  16'sh0000, 1'b0, 36'sd0,          1'b0}
  };

  logic [SizeBits-1:0] phase_sizes [Phases] = '{
    5'd16, 5'd0, 5'd31, 5'd2, 5'd1, 5'd9, 5'd16, 5'd4
  };

  matrix_multiply_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .element_i       (element_i),
    .done_o          (done_o),
    .product_value_o (product_value_o),
    .out_of_range_o  (out_of_range_o)
  );

  always #5ns clk_i = ~clk_i;

  function automatic int live_size();
    if (size_reg == '0) return 1;
    if (size_reg > MaxN) return MaxN;
    return int'(size_reg);
  endfunction

  function automatic c_entry_t compute_c_entry(logic [IdxBits-1:0] row, logic [IdxBits-1:0] col);
    c_entry_t                     res;
    logic signed [ResultBits-1:0] acc;
    int                           n;
    n       = live_size();
    acc     = '0;
    res.oor = 1'b0;
    if (row >= n || col >= n) begin
      res.oor = 1'b1;
    end else begin
      for (int k = 0; k < n; k++) begin
        acc = acc + a_elems[row * MaxN + k] * b_elems[k * MaxN + col];
      end
    end
    res.value = acc;
    return res;
  endfunction

  function automatic bit entry_ready(int r, int c, int n);
    for (int k = 0; k < n; k++) begin
      if (!a_loaded[r * MaxN + k] || !b_loaded[k * MaxN + c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] pick_element();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [KindBits-1:0] kind, input logic [IdxBits-1:0] row,
                           input logic [IdxBits-1:0] col, input logic signed [15:0] elem,
                           input bit typed, input logic signed [ResultBits-1:0] tval,
                           input bit toor);
    c_entry_t entry;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start     = 1'b0;
      kind_i    = KindBits'($urandom());
      row_i     = IdxBits'($urandom());
      col_i     = IdxBits'($urandom());
      element_i = 16'($urandom());
      @(negedge clk_i);
    end
    start     = 1'b1;
    kind_i    = kind;
    row_i     = row;
    col_i     = col;
    element_i = elem;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (kind)
      KindWriteA: begin
        a_elems[row * MaxN + col]  = elem;
        a_loaded[row * MaxN + col] = 1'b1;
      end
      KindWriteB: begin
        b_elems[row * MaxN + col]  = elem;
        b_loaded[row * MaxN + col] = 1'b1;
      end
      KindReadC: begin
        entry = compute_c_entry(row, col);
        if (typed) begin
          entry.value = tval;
          entry.oor   = toor;
        end
        pending_entries.push_back(entry);
      end
      default: ;
    endcase
  endtask

  task automatic send(input logic [KindBits-1:0] kind, input int row, input int col,
                      input logic signed [15:0] elem);
    send_item(kind, IdxBits'(row), IdxBits'(col), elem, 1'b0, '0, 1'b0);
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_entries.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [SizeBits-1:0] val);
    wait_results();
    while (busy) @(negedge clk_i);
    repeat (MaxN + 4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    size_reg = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(input int count);
    int                 r, c, n, pick, sent;
    logic signed [15:0] va, vb;
    sent = 0;
    while (sent < count) begin
      n    = live_size();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // whole row of A and column of B at the extremes, then the entry
        r  = $urandom_range(0, n - 1);
        c  = $urandom_range(0, n - 1);
        va = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        vb = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        for (int k = 0; k < n; k++) begin
          send(KindWriteA, r, k, va);
          send(KindWriteB, k, c, vb);
        end
        send(KindReadC, r, c, pick_element());
        sent += 2 * n + 1;
      end else if (pick < 8) begin
        send(KindSpare, $urandom_range(0, 15), $urandom_range(0, 15), pick_element());
      end else if (pick < 9) begin
        wait_results();
      end else if (pick < 50) begin
        send($urandom_range(0, 1) ? KindWriteB : KindWriteA,
             $urandom_range(0, 15), $urandom_range(0, 15), pick_element());
        sent++;
      end else begin
        if ($urandom_range(0, 6) == 0) begin
          r = $urandom_range(0, 15);
          c = $urandom_range(0, 15);
        end else begin
          r = $urandom_range(0, n - 1);
          c = $urandom_range(0, n - 1);
        end
        if (r < n && c < n && !entry_ready(r, c, n)) begin
          // fill the first missing operand instead
          for (int k = 0; k < n; k++) begin
            if (!a_loaded[r * MaxN + k]) begin
              send(KindWriteA, r, k, pick_element());
              break;
            end
            if (!b_loaded[k * MaxN + c]) begin
              send(KindWriteB, k, c, pick_element());
              break;
            end
          end
        end else begin
          send(KindReadC, r, c, pick_element());
        end
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    c_entry_t want;
    if (rst_ni && done_o) begin
      if (pending_entries.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing pending", product_value_o));
      end else begin
        want = pending_entries.pop_front();
        if (product_value_o !== want.value) begin
          flag_mismatch($sformatf("product_value %0d, want %0d", product_value_o, want.value));
        end
        if (out_of_range_o !== want.oor) begin
          flag_mismatch($sformatf("out_of_range %0b, want %0b", out_of_range_o, want.oor));
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    start          = 1'b0;
    kind_i         = KindWriteA;
    row_i          = '0;
    col_i          = '0;
    element_i      = '0;
    size_reg       = 5'd16;
    mismatch_count = 0;
    idle_pct       = 35;
    for (int i = 0; i < Depth; i++) begin
      a_elems[i]  = '0;
      b_elems[i]  = '0;
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_size(5'd1);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].row, directed_rows[i].col,
                directed_rows[i].elem, directed_rows[i].typed, directed_rows[i].value,
                directed_rows[i].oor);
    end

    for (int p = 0; p < Phases; p++) begin
      idle_pct = (p < 3) ? 35 : (p < 6) ? 71 : 0;
      write_size(phase_sizes[p]);
      run_random(240);
    end

    wait_results();
    repeat (MaxN + 8) @(posedge clk_i);
    if (pending_entries.size() != 0) begin
      flag_mismatch("results still pending at end of run");
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
